// ===== design/qts_pkg.sv =====
// Shared types and constants for the quoted token splitter.
`timescale 1ns / 1ps
`default_nettype none

package qts_pkg;

  // Character codes that steer the tokenizer.
  localparam logic [7:0] CH_BLANK  = 8'h20;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;

  // Default depth of the queue between the front and back parts.
  localparam int QUEUE_DEPTH_DEFAULT = 4;

  // Work for the back part: up to two token bytes and one control result.
  typedef struct packed {
    logic [7:0] byte0;
    logic [7:0] byte1;
    logic [1:0] nbytes;
    logic       has_ctrl;
    logic       ctrl_end;
    logic       ctrl_done;
  } qts_cmd_t;

endpackage

`default_nettype wire

// ===== design/qts_front.sv =====
// Front part: skip counter, tokenizer state machine and command builder.
`timescale 1ns / 1ps
`default_nettype none

module qts_front
  import qts_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_wr_en,
  input  wire logic [7:0] cfg_wr_data,
  input  wire logic       in_accept,
  input  wire logic [7:0] line_byte,
  input  wire logic       line_last,
  output qts_cmd_t        cmd,
  output logic            cmd_push
);

  // Parser modes.
  localparam logic [2:0] M_IDLE       = 3'd0;
  localparam logic [2:0] M_PLAIN      = 3'd1;
  localparam logic [2:0] M_QUOTED     = 3'd2;
  localparam logic [2:0] M_PLAIN_ESC  = 3'd3;
  localparam logic [2:0] M_QUOTED_ESC = 3'd4;

  logic [7:0] skip_length;
  logic [2:0] mode;
  logic [2:0] mode_next;
  logic       nonempty;
  logic       nonempty_next;
  logic [7:0] bytes_seen;
  logic [7:0] bytes_seen_next;
  logic       end_flag;
  logic       is_blank;
  logic       is_quote;
  logic       is_bslash;

  assign is_blank  = (line_byte == CH_BLANK);
  assign is_quote  = (line_byte == CH_QUOTE);
  assign is_bslash = (line_byte == CH_BSLASH);

  // Classify the byte and build the results it causes.
  always_comb begin
    mode_next       = mode;
    nonempty_next   = nonempty;
    bytes_seen_next = bytes_seen;
    end_flag        = 1'b0;
    cmd             = '0;

    if (bytes_seen < skip_length) begin
      bytes_seen_next = bytes_seen + 8'd1;
    end else begin
      unique case (mode)
        M_PLAIN: begin
          if (is_blank) begin
            end_flag      = 1'b1;
            nonempty_next = 1'b0;
            mode_next     = M_IDLE;
          end else if (is_bslash) begin
            mode_next = M_PLAIN_ESC;
          end else if (is_quote) begin
            end_flag      = 1'b1;
            nonempty_next = 1'b0;
            mode_next     = M_QUOTED;
          end else begin
            cmd.byte0     = line_byte;
            cmd.nbytes    = 2'd1;
            nonempty_next = 1'b1;
          end
        end
        M_QUOTED: begin
          if (is_bslash) begin
            mode_next = M_QUOTED_ESC;
          end else if (is_quote) begin
            end_flag      = 1'b1;
            nonempty_next = 1'b0;
            mode_next     = M_IDLE;
          end else begin
            cmd.byte0     = line_byte;
            cmd.nbytes    = 2'd1;
            nonempty_next = 1'b1;
          end
        end
        M_PLAIN_ESC: begin
          // An escaped ordinary byte keeps its backslash.
          if (!is_bslash && !is_quote && !is_blank) begin
            cmd.byte0  = CH_BSLASH;
            cmd.byte1  = line_byte;
            cmd.nbytes = 2'd2;
          end else begin
            cmd.byte0  = line_byte;
            cmd.nbytes = 2'd1;
          end
          nonempty_next = 1'b1;
          mode_next     = M_PLAIN;
        end
        M_QUOTED_ESC: begin
          if (!is_bslash && !is_quote) begin
            cmd.byte0  = CH_BSLASH;
            cmd.byte1  = line_byte;
            cmd.nbytes = 2'd2;
          end else begin
            cmd.byte0  = line_byte;
            cmd.nbytes = 2'd1;
          end
          nonempty_next = 1'b1;
          mode_next     = M_QUOTED;
        end
        default: begin
          // Between tokens; unused codes behave the same way.
          if (is_blank) begin
            mode_next = M_IDLE;
          end else if (is_quote) begin
            mode_next = M_QUOTED;
          end else if (is_bslash) begin
            mode_next = M_PLAIN_ESC;
          end else begin
            cmd.byte0     = line_byte;
            cmd.nbytes    = 2'd1;
            nonempty_next = 1'b1;
            mode_next     = M_PLAIN;
          end
        end
      endcase
    end

    // Line end closes a non-empty token and returns to the reset state.
    if (line_last) begin
      cmd.has_ctrl    = 1'b1;
      cmd.ctrl_end    = end_flag | nonempty_next;
      cmd.ctrl_done   = 1'b1;
      mode_next       = M_IDLE;
      nonempty_next   = 1'b0;
      bytes_seen_next = 8'd0;
    end else if (end_flag) begin
      cmd.has_ctrl = 1'b1;
      cmd.ctrl_end = 1'b1;
    end
  end

  assign cmd_push = in_accept && ((cmd.nbytes != 2'd0) || cmd.has_ctrl);

  // Parser state and skip register.
  always_ff @(posedge clk) begin
    if (rst) begin
      skip_length <= 8'd0;
      mode        <= M_IDLE;
      nonempty    <= 1'b0;
      bytes_seen  <= 8'd0;
    end else begin
      if (cfg_wr_en) begin
        skip_length <= cfg_wr_data;
      end
      if (in_accept) begin
        mode       <= mode_next;
        nonempty   <= nonempty_next;
        bytes_seen <= bytes_seen_next;
      end
    end
  end

endmodule

`default_nettype wire

// ===== design/qts_queue.sv =====
// Short command queue between the front and back parts.
`timescale 1ns / 1ps
`default_nettype none

module qts_queue
  import qts_pkg::*;
#(
  parameter int Depth = QUEUE_DEPTH_DEFAULT
) (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     push,
  input  wire qts_cmd_t push_cmd,
  output logic          full,
  input  wire logic     pop,
  output qts_cmd_t      head,
  output logic          head_valid
);

  localparam int PtrW   = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CountW = $clog2(Depth + 1);

  qts_cmd_t          entries [Depth];
  logic [PtrW-1:0]   wr_ptr;
  logic [PtrW-1:0]   rd_ptr;
  logic [CountW-1:0] count;

  assign full       = (count == CountW'(Depth));
  assign head_valid = (count != '0);
  assign head       = entries[rd_ptr];

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrW'(Depth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrW'(Depth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== design/qts_back.sv =====
// Back part: expands each command into result requests on the output register.
`timescale 1ns / 1ps
`default_nettype none

module qts_back
  import qts_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire qts_cmd_t    head,
  input  wire logic        head_valid,
  output logic             pop,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [15:0]      m_tdata,
  output logic             m_tuser,
  output logic             m_tlast
);

  logic [1:0] step;
  logic [1:0] total;
  logic       is_final;
  logic       is_byte;
  logic       load;
  logic [7:0] res_byte;

  // Pick the result at the current step of the head command.
  assign total    = head.nbytes + {1'b0, head.has_ctrl};
  assign is_final = (step == total - 2'd1);
  assign is_byte  = (step < head.nbytes);
  assign res_byte = is_byte ? ((step == 2'd0) ? head.byte0 : head.byte1) : 8'd0;
  assign load     = head_valid && (!m_tvalid || m_tready);
  assign pop      = load && is_final;

  // Step counter within the head command, and the output valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      step     <= 2'd0;
      m_tvalid <= 1'b0;
    end else begin
      if (load) begin
        step <= is_final ? 2'd0 : step + 2'd1;
      end
      if (load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Output register payload.
  always_ff @(posedge clk) begin
    if (load) begin
      m_tdata[7:0]   <= res_byte;
      m_tdata[8]     <= !is_byte && head.ctrl_end;
      m_tdata[9]     <= !is_byte && head.ctrl_done;
      m_tdata[15:10] <= 6'd0;
      m_tuser        <= is_byte;
      m_tlast        <= is_final;
    end
  end

  // A byte result never carries end marks.
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |-> (m_tdata[9:8] == 2'b00))
    else $error("byte result carries an end mark");

  // A control result has a zero byte and at least one mark.
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser) |-> ((m_tdata[7:0] == 8'd0) && (m_tdata[9:8] != 2'b00)))
    else $error("malformed control result");

  // The line-done result always ends the run of its input.
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[9]) |-> m_tlast)
    else $error("line done without run end");

  // The step counter never walks past the head command.
  assert property (@(posedge clk) disable iff (rst)
    head_valid |-> (step < total))
    else $error("step beyond command length");

endmodule

`default_nettype wire

// ===== design/quoted_token_splitter.sv =====
// Top level of the quoted token splitter: front, queue and back parts.
//
// Usage: the slave stream takes one byte of a reply line per request, in
// s_tdata, with s_tlast on the final byte. The first skip_length bytes of
// each line are dropped; the rest is split into tokens on blanks, with
// double quotes and backslash escapes. The master stream gives one result
// per request: a token byte (m_tuser high) or a control result carrying
// token end and line done marks. m_tlast marks the last result of a byte.
// skip_length is written through cfg_wr_en and cfg_wr_data; the user must
// write it only while idle, the block does not enforce this. Results pass
// through the command queue, then the output register. Throughput: one byte
// per cycle while each byte causes at most one result; the back part emits
// one result per cycle, so a byte with two or three results holds the
// output for each of them, and the command queue of QueueDepth entries
// absorbs the difference before s_tready falls. Reset clears the queue,
// m_tvalid, parser state and skip_length. When m_tready is low the result
// holds, the queue fills, then s_tready drops until the receiver drains it.
`timescale 1ns / 1ps
`default_nettype none

module quoted_token_splitter
  import qts_pkg::*;
#(
  parameter int QueueDepth = QUEUE_DEPTH_DEFAULT
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_wr_en,
  input  wire logic [7:0]  cfg_wr_data,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] line_byte
  input  wire logic        s_tlast,   // line_last
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [15:0]      m_tdata,   // [7:0] token_byte, [8] token_end, [9] line_done
  output logic             m_tuser,   // byte_valid
  output logic             m_tlast    // run_last
);

  qts_cmd_t cmd;
  qts_cmd_t head;
  logic     cmd_push;
  logic     full;
  logic     head_valid;
  logic     pop;
  logic     in_accept;

  assign s_tready  = !full;
  assign in_accept = s_tvalid && s_tready;

  // Tokenizer front.
  qts_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_accept   (in_accept),
    .line_byte   (s_tdata),
    .line_last   (s_tlast),
    .cmd         (cmd),
    .cmd_push    (cmd_push)
  );

  // Command queue.
  qts_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (cmd_push),
    .push_cmd   (cmd),
    .full       (full),
    .pop        (pop),
    .head       (head),
    .head_valid (head_valid)
  );

  // Result emitter.
  qts_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser),
    .m_tlast    (m_tlast)
  );

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
// Self-checking testbench for the quoted token splitter.
`timescale 1ns / 1ps

module testbench;
  import qts_pkg::*;

  // One line byte as it goes to the slave stream.
  typedef struct packed {
    logic [7:0] line_byte;
    logic       line_last;
  } line_item_t;

  // One result as it comes from the master stream.
  typedef struct packed {
    logic [7:0] tok_byte;
    logic       byte_valid;
    logic       tok_end;
    logic       line_done;
    logic       run_last;
  } tok_result_t;

  // Tokenizer modes of the expected-behavior model.
  typedef enum logic [2:0] {
    ST_BETWEEN,
    ST_PLAIN,
    ST_QUOTED,
    ST_PLAIN_ESC,
    ST_QUOTED_ESC
  } parse_state_t;

  // Patterns of the receiver's ready signal.
  localparam int RDY_OPEN    = 0;
  localparam int RDY_COIN    = 1;
  localparam int RDY_CADENCE = 2;

  localparam int HOLD_AT     = 90;
  localparam int HOLD_CYCLES = 300;
  localparam int SETTLE      = 8;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_wr_en = 1'b0;
  logic [7:0]  cfg_wr_data = 8'd0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'd0;   // [7:0] line_byte
  logic        s_tlast = 1'b0;   // line_last
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;          // [7:0] token_byte, [8] token_end, [9] line_done
  logic        m_tuser;          // byte_valid
  logic        m_tlast;          // run_last

  // Stimulus and expectation stores.
  line_item_t   line_bytes_q[$];
  tok_result_t  want_q[$];

  // Model state and configuration.
  parse_state_t state_model = ST_BETWEEN;
  logic         tok_open = 1'b0;
  logic [7:0]   seen_cnt = 8'd0;
  logic [7:0]   skip_model = 8'd0;

  // Run bookkeeping.
  int bytes_queued = 0;
  int bytes_taken = 0;
  int lines_queued = 0;
  int results_seen = 0;
  int mismatches = 0;
  int skip_writes = 0;
  int gap_left = 0;
  int burst_left = 0;
  int seg_left = 0;
  int seg_mode = RDY_OPEN;
  logic hold_off = 1'b0;

  quoted_token_splitter dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tlast     (s_tlast),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser),
    .m_tlast     (m_tlast)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // A token byte result; the open token now holds data.
  function automatic void add_token_byte(input logic [7:0] c);
    tok_result_t r;
    r = '{tok_byte: c, byte_valid: 1'b1, tok_end: 1'b0, line_done: 1'b0, run_last: 1'b0};
    want_q.insert(want_q.size(), r);
    tok_open = 1'b1;
  endfunction

  // A control result carrying token end and line done marks.
  function automatic void add_mark(input logic tok_end, input logic line_done);
    tok_result_t r;
    r = '{tok_byte: 8'd0, byte_valid: 1'b0, tok_end: tok_end, line_done: line_done,
          run_last: 1'b0};
    want_q.insert(want_q.size(), r);
  endfunction

  // Works out the results one accepted line byte causes.
  function automatic void split_byte(input logic [7:0] c, input logic last);
    logic        close;
    int          first;
    close = 1'b0;
    first = want_q.size();
    if (seen_cnt < skip_model) begin
      seen_cnt = seen_cnt + 8'd1;
    end else begin
      case (state_model)
        ST_PLAIN: begin
          if (c == CH_BLANK || c == CH_QUOTE) begin
            close = 1'b1;
            tok_open = 1'b0;
            state_model = (c == CH_QUOTE) ? ST_QUOTED : ST_BETWEEN;
          end else if (c == CH_BSLASH) begin
            state_model = ST_PLAIN_ESC;
          end else begin
            add_token_byte(c);
          end
        end
        ST_QUOTED: begin
          if (c == CH_BSLASH) begin
            state_model = ST_QUOTED_ESC;
          end else if (c == CH_QUOTE) begin
            close = 1'b1;
            tok_open = 1'b0;
            state_model = ST_BETWEEN;
          end else begin
            add_token_byte(c);
          end
        end
        ST_PLAIN_ESC: begin
          // An ordinary byte keeps its backslash; blank, quote and backslash lose it.
          if (c != CH_BSLASH && c != CH_QUOTE && c != CH_BLANK) add_token_byte(CH_BSLASH);
          add_token_byte(c);
          state_model = ST_PLAIN;
        end
        ST_QUOTED_ESC: begin
          if (c != CH_BSLASH && c != CH_QUOTE) add_token_byte(CH_BSLASH);
          add_token_byte(c);
          state_model = ST_QUOTED;
        end
        default: begin
          if (c == CH_QUOTE) begin
            state_model = ST_QUOTED;
          end else if (c == CH_BSLASH) begin
            state_model = ST_PLAIN_ESC;
          end else if (c != CH_BLANK) begin
            add_token_byte(c);
            state_model = ST_PLAIN;
          end else begin
            state_model = ST_BETWEEN;
          end
        end
      endcase
    end
    // Line end flushes a non-empty token and clears all state.
    if (last) begin
      if (tok_open) close = 1'b1;
      add_mark(close, 1'b1);
      state_model = ST_BETWEEN;
      tok_open = 1'b0;
      seen_cnt = 8'd0;
    end else if (close) begin
      add_mark(1'b1, 1'b0);
    end
    if (want_q.size() > first) begin
      want_q[want_q.size() - 1].run_last = 1'b1;
    end
  endfunction

  task automatic queue_byte(input logic [7:0] b, input logic last);
    line_item_t it;
    it.line_byte = b;
    it.line_last = last;
    line_bytes_q.insert(line_bytes_q.size(), it);
    bytes_queued++;
    if (last) lines_queued++;
  endtask

  task automatic queue_line(input string s);
    for (int i = 0; i < s.len(); i++) queue_byte(s[i], i == s.len() - 1);
  endtask

  // Waits until every byte is in and every result out, then lets the pipe drain.
  task automatic wait_idle();
    while (line_bytes_q.size() != 0 || want_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_skip(input logic [7:0] v);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    skip_model = v;
    skip_writes++;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Any byte but blank, quote and backslash, mostly lower-case letters.
  function automatic logic [7:0] plain_char();
    logic [7:0] c;
    if ($urandom_range(0, 3) != 0) return 8'(97 + $urandom_range(0, 25));
    c = 8'($urandom_range(0, 255));
    while (c == CH_BLANK || c == CH_QUOTE || c == CH_BSLASH) c = 8'($urandom_range(0, 255));
    return c;
  endfunction

  // One reply line: the echoed prefix, then mostly well-formed tokens, sometimes noise.
  task automatic gen_line(input int prefix);
    logic [7:0] chars[$];
    int ntok;
    int len;
    int pick;
    logic in_q;
    repeat (prefix) chars.insert(chars.size(), 8'($urandom_range(0, 255)));
    if ($urandom_range(0, 7) == 0) begin
      repeat ($urandom_range(1, 8)) begin
        pick = $urandom_range(0, 7);
        chars.insert(chars.size(), pick == 0 ? CH_BLANK : pick == 1 ? CH_QUOTE :
                     pick == 2 ? CH_BSLASH : 8'($urandom_range(0, 255)));
      end
    end else begin
      ntok = $urandom_range(1, 4);
      for (int t = 0; t < ntok; t++) begin
        if (t > 0 || $urandom_range(0, 3) == 0) begin
          repeat ($urandom_range(1, 2)) chars.insert(chars.size(), CH_BLANK);
        end
        in_q = 1'($urandom_range(0, 1));
        len = in_q ? $urandom_range(0, 5) : $urandom_range(1, 5);
        if (in_q) chars.insert(chars.size(), CH_QUOTE);
        repeat (len) begin
          pick = $urandom_range(0, 9);
          if (pick == 0) begin
            chars.insert(chars.size(), CH_BSLASH);
            pick = $urandom_range(0, 3);
            chars.insert(chars.size(), pick == 0 ? CH_BLANK : pick == 1 ? CH_QUOTE :
                         pick == 2 ? CH_BSLASH : plain_char());
          end else if (pick == 1 && in_q) begin
            chars.insert(chars.size(), CH_BLANK);
          end else begin
            chars.insert(chars.size(), plain_char());
          end
        end
        // Now and then the last quoted token is left open.
        if (in_q && (t < ntok - 1 || $urandom_range(0, 5) != 0)) begin
          chars.insert(chars.size(), CH_QUOTE);
        end
      end
      if ($urandom_range(0, 3) == 0) chars.insert(chars.size(), CH_BLANK);
    end
    foreach (chars[i]) queue_byte(chars[i], i == chars.size() - 1);
  endtask

  // Sender: offers queued bytes in bursts, holding each until it is taken.
  always @(posedge clk) begin
    line_item_t nxt;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        split_byte(s_tdata, s_tlast);
        nxt = line_bytes_q.pop_front();
        bytes_taken++;
      end
      if (!s_tvalid || s_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          s_tvalid <= 1'b0;
        end else if (line_bytes_q.size() > 0) begin
          nxt = line_bytes_q[0];
          s_tvalid <= 1'b1;
          s_tdata <= nxt.line_byte;
          s_tlast <= nxt.line_last;
          if (burst_left > 0) burst_left--;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: checks each taken result and stalls in segments of varying pattern.
  always @(posedge clk) begin
    tok_result_t w;
    logic rdy;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        results_seen++;
        if (want_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("result %0d unexpected: byte %02h valid %0b end %0b done %0b last %0b",
                     results_seen, m_tdata[7:0], m_tuser, m_tdata[8], m_tdata[9], m_tlast);
          end
        end else begin
          w = want_q.pop_front();
          if (m_tdata[7:0] !== w.tok_byte || m_tuser !== w.byte_valid ||
              m_tdata[8] !== w.tok_end || m_tdata[9] !== w.line_done ||
              m_tlast !== w.run_last) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("result %0d differs: expected byte %02h valid %0b end %0b done %0b last %0b",
                       results_seen, w.tok_byte, w.byte_valid, w.tok_end, w.line_done,
                       w.run_last);
              $display("  got byte %02h valid %0b end %0b done %0b last %0b",
                       m_tdata[7:0], m_tuser, m_tdata[8], m_tdata[9], m_tlast);
            end
          end
        end
      end
      if (hold_off) begin
        m_tready <= 1'b0;
      end else begin
        if (seg_left == 0) begin
          seg_mode = $urandom_range(RDY_OPEN, RDY_CADENCE);
          seg_left = $urandom_range(4, 40);
        end
        seg_left--;
        case (seg_mode)
          RDY_OPEN: rdy = 1'b1;
          RDY_COIN: rdy = 1'($urandom_range(0, 1));
          default:  rdy = (seg_left % 3) != 0;
        endcase
        m_tready <= rdy;
      end
    end
  end

  // One long receiver hold-off while the sender keeps offering bytes.
  initial begin
    while (bytes_taken < HOLD_AT) @(posedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  // Run limit.
  initial begin
    #4000000;
    $display("quoted_token_splitter: mismatch");
    $finish;
  end

  // Phase sequence: reset, directed lines, then random lines under several skip settings.
  initial begin
    int phase_skip[4];
    int target;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Plain tokens, escapes, quoted tokens, empty and dangling tokens, byte extremes.
    write_skip(8'd0);
    queue_line("ab c");
    queue_line("x\\n\\ y");
    queue_line("q\"r s\\\"\"");
    queue_line("\"\" \"\\a\"");
    queue_line("z \"");
    queue_line("\\");
    queue_byte(8'h00, 1'b0);
    queue_byte(8'hFF, 1'b0);
    queue_byte(CH_BLANK, 1'b0);
    queue_byte(8'hFF, 1'b1);
    wait_idle();

    // A line that ends inside the prefix, then the prefix shortened mid-line.
    write_skip(8'd4);
    queue_line("xy");
    queue_byte("a", 1'b0);
    queue_byte("b", 1'b0);
    wait_idle();
    write_skip(8'd1);
    queue_line("cd e");
    wait_idle();

    // Random lines; under the longest prefix every line ends while still skipping.
    phase_skip[0] = 3;
    phase_skip[1] = 255;
    phase_skip[2] = 0;
    phase_skip[3] = $urandom_range(1, 12);
    foreach (phase_skip[p]) begin
      write_skip(8'(phase_skip[p]));
      if (phase_skip[p] == 255) begin
        repeat (3) gen_line(0);
      end else begin
        target = bytes_queued + 65;
        while (bytes_queued < target) gen_line(phase_skip[p]);
      end
      wait_idle();
    end

    $display("Covered %0d line bytes in %0d lines, %0d results checked, %0d skip settings.",
             bytes_taken, lines_queued, results_seen, skip_writes);
    $display("Sender bursts, receiver stall patterns and one long output hold-off were mixed in.");
    if (mismatches == 0 && want_q.size() == 0) begin
      $display("quoted_token_splitter: match");
    end else begin
      $display("quoted_token_splitter: mismatch");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/qts_pkg.sv
design/qts_front.sv
design/qts_queue.sv
design/qts_back.sv
design/quoted_token_splitter.sv
tb/testbench.sv
